### rtl/glsch_pkg.sv
// Shared constants and types for the greedy list scheduler.
package glsch_pkg;

    localparam int TASK_W        = 16;
    localparam int LOAD_W        = 32;
    localparam int PROCS_W       = 5;
    localparam int MACH_W        = 4;
    localparam int MAX_PROCS_DEF = 16;

    localparam logic [PROCS_W-1:0] PROCS_RESET = 5'd16;
    localparam logic [LOAD_W-1:0]  LOAD_MAX    = {LOAD_W{1'b1}};

    // Best candidate seen so far while the search walks along the cells.
    typedef struct packed {
        logic              vld;
        logic [LOAD_W-1:0] load;
    } t_cand;

endpackage

### rtl/glsch_cell.sv
// One machine cell: holds a machine load and compares it against the passing candidate.
module glsch_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_active,
    input  glsch_pkg::t_cand              i_cand,
    input  logic [IDX_W-1:0]              i_cand_idx,
    input  logic                          i_wr,
    input  logic [glsch_pkg::LOAD_W-1:0]  i_wr_load,
    output glsch_pkg::t_cand              o_cand,
    output logic [IDX_W-1:0]              o_cand_idx
);
    import glsch_pkg::*;

    logic [LOAD_W-1:0] r_load;
    t_cand             r_cand;
    t_cand             n_cand;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              take;

    // Strict compare keeps the lower index on a tie.
    assign take = i_active && (r_load < i_cand.load);

    always_comb begin
        n_cand.vld = i_cand.vld;
        if (take) begin
            n_cand.load = r_load;
            n_idx       = IDX_W'(CELL_IDX);
        end else begin
            n_cand.load = i_cand.load;
            n_idx       = i_cand_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load     <= '0;
            r_cand.vld <= 1'b0;
        end else begin
            if (i_wr) begin
                r_load <= i_wr_load;
            end
            r_cand.vld <= n_cand.vld;
        end
        r_cand.load <= n_cand.load;
        r_idx       <= n_idx;
    end

    assign o_cand     = r_cand;
    assign o_cand_idx = r_idx;

endmodule

### rtl/greedy_list_scheduler.sv
// Top level of the greedy list scheduler: machine cell chain, result register and config.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------------
//  task     | i_task_valid / o_task_ready    | i_task_time
//  result   | o_res_valid / i_res_ready      | o_chosen_machine, o_new_load
//  config   | i_cfg_we (no wait)             | i_cfg_wdata (num_procs)
//
// A task walks the chain of MAX_PROCS cells, one cell per cycle, and its result is registered
// into the result register after the last cell; a new task is taken only once the search has
// left the chain and no result is held.
// The chosen cell is updated in the cycle the search leaves the chain.
// Reset clears all loads and sets num_procs to 16; reset is synchronous.
// A stalled result waits in a holding register, which holds off the task side as well.
module greedy_list_scheduler #(
    parameter int MAX_PROCS = glsch_pkg::MAX_PROCS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [glsch_pkg::PROCS_W-1:0] i_cfg_wdata,
    input  logic                          i_task_valid,
    output logic                          o_task_ready,
    input  logic [glsch_pkg::TASK_W-1:0]  i_task_time,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [glsch_pkg::MACH_W-1:0]  o_chosen_machine,
    output logic [glsch_pkg::LOAD_W-1:0]  o_new_load
);
    import glsch_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_B = $clog2(MAX_PROCS + 1);
    localparam int CW    = (CNT_B > PROCS_W) ? CNT_B : PROCS_W;

    logic [PROCS_W-1:0] r_num_procs;
    logic [CW-1:0]      num_ext;
    logic [CW-1:0]      act_cnt;
    logic [TASK_W-1:0]  r_task;
    logic               r_busy;
    logic               r_pend_vld;
    logic [IDX_W-1:0]   r_pend_idx;
    logic [LOAD_W-1:0]  r_pend_load;
    logic               r_out_vld;
    logic [IDX_W-1:0]   r_out_idx;
    logic [LOAD_W-1:0]  r_out_load;

    t_cand              cand     [MAX_PROCS+1];
    logic [IDX_W-1:0]   cand_idx [MAX_PROCS+1];
    logic [MAX_PROCS-1:0] active;
    logic [MAX_PROCS-1:0] wr;
    logic [MAX_PROCS-1:0] cand_vld;

    logic               task_acc;
    logic               done;
    logic               out_free;
    logic [LOAD_W:0]    sum;
    logic [LOAD_W-1:0]  new_load;

    assign o_task_ready = !r_busy && !r_pend_vld;
    assign task_acc     = i_task_valid && o_task_ready;

    // A num_procs of zero still schedules on machine 0; large values clamp to the chain length.
    always_comb begin
        num_ext = CW'(r_num_procs);
        if (num_ext == '0) begin
            act_cnt = CW'(1);
        end else if (num_ext > CW'(MAX_PROCS)) begin
            act_cnt = CW'(MAX_PROCS);
        end else begin
            act_cnt = num_ext;
        end
    end

    assign cand[0].vld  = task_acc;
    assign cand[0].load = LOAD_MAX;
    assign cand_idx[0]  = '0;

    assign done     = cand[MAX_PROCS].vld;
    assign sum      = {1'b0, cand[MAX_PROCS].load} + (LOAD_W+1)'(r_task);
    assign new_load = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
    assign out_free = !r_out_vld || i_res_ready;

    always_comb begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            active[i]   = CW'(i) < act_cnt;
            wr[i]       = done && (cand_idx[MAX_PROCS] == IDX_W'(i));
            cand_vld[i] = cand[i+1].vld;
        end
    end

    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        glsch_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_active   (active[g]),
            .i_cand     (cand[g]),
            .i_cand_idx (cand_idx[g]),
            .i_wr       (wr[g]),
            .i_wr_load  (new_load),
            .o_cand     (cand[g+1]),
            .o_cand_idx (cand_idx[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= PROCS_RESET;
            r_busy      <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_procs <= i_cfg_wdata;
            end
            if (task_acc) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                if (r_pend_vld) begin
                    r_out_vld  <= 1'b1;
                    r_pend_vld <= 1'b0;
                end else begin
                    r_out_vld <= done;
                end
            end else if (done) begin
                r_pend_vld <= 1'b1;
            end
        end
        if (task_acc) begin
            r_task <= i_task_time;
        end
        if (out_free) begin
            if (r_pend_vld) begin
                r_out_idx  <= r_pend_idx;
                r_out_load <= r_pend_load;
            end else if (done) begin
                r_out_idx  <= cand_idx[MAX_PROCS];
                r_out_load <= new_load;
            end
        end else if (done) begin
            r_pend_idx  <= cand_idx[MAX_PROCS];
            r_pend_load <= new_load;
        end
    end

    assign o_res_valid      = r_out_vld;
    assign o_chosen_machine = MACH_W'(r_out_idx);
    assign o_new_load       = r_out_load;

`ifndef SYNTHESIS
    // Only one search may be in flight along the chain.
    a_one_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cand_vld))
        else $error("more than one search in the cell chain");

    // A held result and a finishing search never meet.
    a_pend_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend_vld && done))
        else $error("search finished while a result was still held");

    // The scheduler frees itself once the search leaves the chain.
    a_busy_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> !r_busy)
        else $error("busy not cleared after search completion");

    // No new task is taken while a search is running.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        task_acc |-> ($countones(cand_vld) == 0))
        else $error("task accepted during a running search");
`endif

endmodule
